FILE: rtl/svr_pkg.sv
// ----------------------------------------------------------------------------
// svr_pkg
// Shared types, constants and functions for the settings record validator.
// ----------------------------------------------------------------------------
package svr_pkg;

  localparam int unsigned REC_LEN  = 24;
  localparam int unsigned CRC_LEN  = 20;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 8'd1;

  localparam logic [IDX_W-1:0] IDX_LAST = 5'(REC_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_CRC_END = 5'(CRC_LEN);

  localparam logic [15:0] REC_SIZE = 16'(REC_LEN);

  localparam logic [31:0] FREQ_MAX  = 32'd100000;
  localparam logic [15:0] DUTY_MAX  = 16'd100;
  localparam logic [15:0] FSTEP_MAX = 16'd10000;
  localparam logic [7:0]  DSTEP_MAX = 8'd10;

  localparam logic [16:0] DEF_FREQ  = 17'd50000;
  localparam logic [6:0]  DEF_DUTY  = 7'd50;
  localparam logic [13:0] DEF_FSTEP = 14'd1000;
  localparam logic [3:0]  DEF_DSTEP = 4'd1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MIGRATED  = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_VER   = 3'd3,
    ST_BAD_SIZE  = 3'd4,
    ST_BAD_CRC   = 3'd5,
    ST_BAD_RANGE = 3'd6
  } status_t;

  typedef logic [REC_LEN-1:0][7:0] rec_bytes_t;

  typedef struct packed {
    status_t     status;
    logic [16:0] frequency;
    logic [6:0]  duty;
    logic [13:0] freq_incr;
    logic [3:0]  duty_incr;
    logic        needs_rewrite;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic values_ok(input logic [31:0] f, input logic [15:0] d,
                                     input logic [15:0] fs, input logic [7:0] ds);
    logic ok;
    ok = (f != 32'd0) && (f <= FREQ_MAX) &&
         (d != 16'd0) && (d <= DUTY_MAX) &&
         (fs != 16'd0) && (fs <= FSTEP_MAX) &&
         (ds != 8'd0) && (ds <= DSTEP_MAX);
    return ok;
  endfunction

endpackage

FILE: rtl/svr_byte_if.sv
// ----------------------------------------------------------------------------
// svr_byte_if
// Input stream channel: one record byte per item.
// ----------------------------------------------------------------------------
interface svr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: rtl/svr_result_if.sv
// ----------------------------------------------------------------------------
// svr_result_if
// Result stream channel: validated, migrated or default settings.
// ----------------------------------------------------------------------------
interface svr_result_if;
  logic             valid;
  logic             ready;
  svr_pkg::status_t status;
  logic [16:0]      frequency;
  logic [6:0]       duty;
  logic [13:0]      freq_incr;
  logic [3:0]       duty_incr;
  logic             needs_rewrite;

  modport source (output valid, output status, output frequency, output duty,
                  output freq_incr, output duty_incr, output needs_rewrite,
                  input ready);
  modport sink   (input valid, input status, input frequency, input duty,
                  input freq_incr, input duty_incr, input needs_rewrite,
                  output ready);
endinterface

FILE: rtl/svr_cfg_if.sv
// ----------------------------------------------------------------------------
// svr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface svr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [svr_pkg::CFG_IDX_W-1:0]       index;
  logic [svr_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/settings_record_validator_top.sv
// ----------------------------------------------------------------------------
// settings_record_validator_top
// Settings record validator: CRC-32 and field checks over a 24-byte record.
// ----------------------------------------------------------------------------
// Feed a 24-byte little-endian settings record one byte per item; one byte is
// accepted every clock cycle while the result side keeps up. The CRC-32 over
// bytes 0 to 19 is updated by a byte-wide step as each byte lands in the
// record store. After the 24th byte is accepted a pending flag is registered;
// then the checks run on the stored record and the result enters the output
// register once free, to wait while input streams. Input stalls only when a
// finished record waits for its check while the output register is still
// held. Write record_magic (index 0) and record_version (index 1) while idle.
// ----------------------------------------------------------------------------
module settings_record_validator_top (
  input  logic                clk,
  input  logic                rst_n,
  svr_byte_if.sink            in_if,
  svr_result_if.source        out_if,
  svr_cfg_if.sink             cfg_if
);

  logic [31:0]         magic_r;
  logic [15:0]         version_r;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  svr_pkg::result_t    out_r, check_res;
  svr_pkg::rec_bytes_t store;
  logic [31:0]         crc;
  logic                rec_done, in_accept, out_free, load_out;

  assign out_free  = !out_valid_r || out_if.ready;
  assign load_out  = pend_r && out_free;
  assign in_if.ready = !pend_r || out_free;
  assign in_accept = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        svr_pkg::REG_MAGIC:   magic_r   <= cfg_if.data;
        svr_pkg::REG_VERSION: version_r <= cfg_if.data[15:0];
        default: ;
      endcase
    end
  end

  svr_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_if.data_byte),
    .store     (store),
    .crc       (crc),
    .rec_done  (rec_done)
  );

  svr_check u_check (
    .store          (store),
    .crc            (crc),
    .record_magic   (magic_r),
    .record_version (version_r),
    .result         (check_res)
  );

  always_comb begin
    pend_nxt      = rec_done || (pend_r && !out_free);
    out_valid_nxt = load_out || (out_valid_r && !out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= check_res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_r.status;
  assign out_if.frequency     = out_r.frequency;
  assign out_if.duty          = out_r.duty;
  assign out_if.freq_incr     = out_r.freq_incr;
  assign out_if.duty_incr     = out_r.duty_incr;
  assign out_if.needs_rewrite = out_r.needs_rewrite;

endmodule

FILE: rtl/svr_capture.sv
// ----------------------------------------------------------------------------
// svr_capture
// Byte capture: position counter, record byte store and CRC-32 update.
// ----------------------------------------------------------------------------
module svr_capture (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  output svr_pkg::rec_bytes_t store,
  output logic [31:0]         crc,
  output logic                rec_done
);

  logic [svr_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]               crc_r, crc_nxt, crc_base;
  svr_pkg::rec_bytes_t       store_r;
  logic                      is_last;

  assign is_last  = (idx_r == svr_pkg::IDX_LAST);
  assign crc_base = (idx_r == '0) ? svr_pkg::CRC_INIT : crc_r;

  always_comb begin
    idx_nxt = is_last ? '0 : idx_r + 1'b1;
    crc_nxt = (idx_r < svr_pkg::IDX_CRC_END) ? svr_pkg::crc_byte(crc_base, data_byte)
                                             : crc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      crc_r <= svr_pkg::CRC_INIT;
    end else if (accept) begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store_r[idx_r] <= data_byte;
    end
  end

  assign store    = store_r;
  assign crc      = crc_r;
  assign rec_done = accept && is_last;

endmodule

FILE: rtl/svr_check.sv
// ----------------------------------------------------------------------------
// svr_check
// Record check: first failing status, legacy migration and default fallback.
// ----------------------------------------------------------------------------
module svr_check (
  input  svr_pkg::rec_bytes_t store,
  input  logic [31:0]         crc,
  input  logic [31:0]         record_magic,
  input  logic [15:0]         record_version,
  output svr_pkg::result_t    result
);

  logic [31:0] magic, stored_crc, f, lf;
  logic [15:0] version, size, d, fs, ld, lfs;
  logic [7:0]  ds, lds;
  logic        magic_ok, cur_ok, leg_ok;

  assign magic      = {store[3], store[2], store[1], store[0]};
  assign version    = {store[5], store[4]};
  assign size       = {store[7], store[6]};
  assign f          = {store[11], store[10], store[9], store[8]};
  assign d          = {store[13], store[12]};
  assign fs         = {store[15], store[14]};
  assign ds         = store[16];
  assign stored_crc = {store[23], store[22], store[21], store[20]};

  assign lf  = {store[7], store[6], store[5], store[4]};
  assign ld  = {store[9], store[8]};
  assign lfs = {store[11], store[10]};
  assign lds = store[12];

  assign magic_ok = (magic == record_magic);
  assign cur_ok   = svr_pkg::values_ok(f, d, fs, ds);
  assign leg_ok   = magic_ok && svr_pkg::values_ok(lf, ld, lfs, lds);

  always_comb begin
    svr_pkg::status_t st;
    priority if (!magic_ok)                st = svr_pkg::ST_BAD_MAGIC;
    else if (version != record_version)    st = svr_pkg::ST_BAD_VER;
    else if (size != svr_pkg::REC_SIZE)    st = svr_pkg::ST_BAD_SIZE;
    else if (stored_crc != ~crc)           st = svr_pkg::ST_BAD_CRC;
    else if (!cur_ok)                      st = svr_pkg::ST_BAD_RANGE;
    else                                   st = svr_pkg::ST_OK;

    if (st == svr_pkg::ST_OK) begin
      result.status        = st;
      result.frequency     = f[16:0];
      result.duty          = d[6:0];
      result.freq_incr     = fs[13:0];
      result.duty_incr     = ds[3:0];
      result.needs_rewrite = 1'b0;
    end else if (leg_ok) begin
      result.status        = svr_pkg::ST_MIGRATED;
      result.frequency     = lf[16:0];
      result.duty          = ld[6:0];
      result.freq_incr     = lfs[13:0];
      result.duty_incr     = lds[3:0];
      result.needs_rewrite = 1'b1;
    end else begin
      result.status        = st;
      result.frequency     = svr_pkg::DEF_FREQ;
      result.duty          = svr_pkg::DEF_DUTY;
      result.freq_incr     = svr_pkg::DEF_FSTEP;
      result.duty_incr     = svr_pkg::DEF_DSTEP;
      result.needs_rewrite = 1'b1;
    end
  end

endmodule

FILE: dv/settings_record_validator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// settings_record_validator_top_test
// Streams 24-byte settings records through the validator. Records are built
// well formed, from the legacy layout, with one broken check, or as noise,
// and some are cut short to knock the stream out of step. Each accepted byte
// feeds a local model of the CRC and the field checks. Each result is compared
// field by field with the oldest predicted one. The magic and version
// registers change between phases, with sender gaps and receiver stalls
// throughout and one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module settings_record_validator_top_test;
  import svr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned PHASES      = 4;
  localparam int unsigned RECS_PER_PHASE = 6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'hFF;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  svr_byte_if   in_ch();
  svr_result_if out_ch();
  svr_cfg_if    cfg_ch();

  settings_record_validator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #6 clk = ~clk;

  // model of the block
  logic [31:0] model_magic   = '0;
  logic [15:0] model_version = '0;
  int unsigned rec_pos       = 0;
  logic [31:0] crc_acc       = CRC_INIT;
  rec_bytes_t  rec_seen;
  result_t     settings_due[$];

  // stimulus side
  logic [7:0]  bytes_pending[$];
  int unsigned bytes_queued = 0;
  logic [31:0] stim_magic;
  logic [15:0] stim_version;

  // shared counters; all but errors are written nonblocking at the rising edge
  int unsigned bytes_taken = 0;
  int unsigned cfg_writes  = 0;
  int unsigned cycles      = 0;
  int unsigned errors      = 0;

  int unsigned drv_seen   = 0;
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;
  int unsigned hold_left  = 0;
  bit          long_hold_done = 1'b0;
  logic [15:0] stall_pat  = '1;
  int unsigned stall_age  = 0;

  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = {1'b0, c[31:1]};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [31:0] le_field(rec_bytes_t r, int at, int n);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < n; k++) v[8*k +: 8] = r[at+k];
    return v;
  endfunction

  function automatic bit settings_in_range(logic [31:0] f, logic [31:0] d,
                                           logic [31:0] fs, logic [31:0] ds);
    return f  >= 1 && f  <= FREQ_MAX  && d  >= 1 && d  <= DUTY_MAX &&
           fs >= 1 && fs <= FSTEP_MAX && ds >= 1 && ds <= DSTEP_MAX;
  endfunction

  function automatic logic [31:0] record_crc(rec_bytes_t r);
    logic [31:0] c;
    c = CRC_INIT;
    for (int k = 0; k < CRC_LEN; k++) c = crc32_step(c, r[k]);
    return ~c;
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    result_t     res;
    logic [31:0] f, d, fs, ds;
    rec_seen[rec_pos] = b;
    if (rec_pos < CRC_LEN) crc_acc = crc32_step(crc_acc, b);
    if (rec_pos < REC_LEN - 1) begin
      rec_pos++;
    end else begin
      f  = le_field(rec_seen, 8, 4);
      d  = le_field(rec_seen, 12, 2);
      fs = le_field(rec_seen, 14, 2);
      ds = le_field(rec_seen, 16, 1);
      if (le_field(rec_seen, 0, 4) != model_magic) res.status = ST_BAD_MAGIC;
      else if (le_field(rec_seen, 4, 2) != model_version) res.status = ST_BAD_VER;
      else if (le_field(rec_seen, 6, 2) != REC_LEN) res.status = ST_BAD_SIZE;
      else if (le_field(rec_seen, 20, 4) != ~crc_acc) res.status = ST_BAD_CRC;
      else if (!settings_in_range(f, d, fs, ds)) res.status = ST_BAD_RANGE;
      else res.status = ST_OK;
      res.needs_rewrite = (res.status != ST_OK);
      if (res.status != ST_OK) begin
        if (le_field(rec_seen, 0, 4) == model_magic &&
            settings_in_range(le_field(rec_seen, 4, 4), le_field(rec_seen, 8, 2),
                              le_field(rec_seen, 10, 2), le_field(rec_seen, 12, 1))) begin
          res.status = ST_MIGRATED;
          f  = le_field(rec_seen, 4, 4);
          d  = le_field(rec_seen, 8, 2);
          fs = le_field(rec_seen, 10, 2);
          ds = le_field(rec_seen, 12, 1);
        end else begin
          f  = 32'(DEF_FREQ);
          d  = 32'(DEF_DUTY);
          fs = 32'(DEF_FSTEP);
          ds = 32'(DEF_DSTEP);
        end
      end
      res.frequency = f[16:0];
      res.duty      = d[6:0];
      res.freq_incr = fs[13:0];
      res.duty_incr = ds[3:0];
      settings_due.push_back(res);
      rec_pos = 0;
      crc_acc = CRC_INIT;
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic check_settings();
    result_t want;
    if (settings_due.size() == 0) begin
      report("unexpected result, status", out_ch.status, -1);
    end else begin
      want = settings_due.pop_front();
      if (out_ch.status != want.status) report("status", out_ch.status, want.status);
      if (out_ch.frequency != want.frequency)
        report("frequency", out_ch.frequency, want.frequency);
      if (out_ch.duty != want.duty) report("duty", out_ch.duty, want.duty);
      if (out_ch.freq_incr != want.freq_incr)
        report("freq_incr", out_ch.freq_incr, want.freq_incr);
      if (out_ch.duty_incr != want.duty_incr)
        report("duty_incr", out_ch.duty_incr, want.duty_incr);
      if (out_ch.needs_rewrite != want.needs_rewrite)
        report("needs_rewrite", out_ch.needs_rewrite, want.needs_rewrite);
    end
  endtask

  // in range, extremes often
  function automatic logic [31:0] pick_in(logic [31:0] hi);
    case ($urandom_range(0, 9))
      0: return 32'd1;
      1: return hi;
      default: return $urandom_range(1, hi);
    endcase
  endfunction

  function automatic logic [31:0] pick_out(logic [31:0] hi, logic [31:0] cap);
    case ($urandom_range(0, 2))
      0: return 32'd0;
      1: return hi + 1;
      default: return $urandom_range(hi + 1, cap);
    endcase
  endfunction

  function automatic rec_bytes_t current_record(logic [31:0] magic, logic [15:0] version,
                                                logic [15:0] size, logic [31:0] f,
                                                logic [15:0] d, logic [15:0] fs,
                                                logic [7:0] ds);
    rec_bytes_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    {r[3], r[2], r[1], r[0]}     = magic;
    {r[5], r[4]}                 = version;
    {r[7], r[6]}                 = size;
    {r[11], r[10], r[9], r[8]}   = f;
    {r[13], r[12]}               = d;
    {r[15], r[14]}               = fs;
    r[16]                        = ds;
    {r[23], r[22], r[21], r[20]} = record_crc(r);
    return r;
  endfunction

  function automatic rec_bytes_t legacy_record(logic [31:0] magic);
    rec_bytes_t  r;
    logic [31:0] f;
    logic [15:0] d, fs;
    logic [7:0]  ds;
    r  = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    f  = pick_in(FREQ_MAX);
    d  = 16'(pick_in(32'(DUTY_MAX)));
    fs = 16'(pick_in(32'(FSTEP_MAX)));
    ds = 8'(pick_in(32'(DSTEP_MAX)));
    {r[3], r[2], r[1], r[0]} = magic;
    {r[7], r[6], r[5], r[4]} = f;
    {r[9], r[8]}             = d;
    {r[11], r[10]}           = fs;
    r[12]                    = ds;
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    bytes_pending.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_record(input rec_bytes_t r, input int unsigned len);
    for (int k = 0; k < len; k++) push_byte(r[k]);
  endtask

  task automatic queue_random_record();
    rec_bytes_t  r;
    int unsigned pick, len;
    logic [31:0] f, wrong_magic;
    logic [15:0] d, fs;
    logic [7:0]  ds;
    pick = $urandom_range(0, 99);
    len  = REC_LEN;
    f    = pick_in(FREQ_MAX);
    d    = 16'(pick_in(32'(DUTY_MAX)));
    fs   = 16'(pick_in(32'(FSTEP_MAX)));
    ds   = 8'(pick_in(32'(DSTEP_MAX)));
    wrong_magic = stim_magic ^ (32'd1 << $urandom_range(0, 31));
    if (pick < 30) begin
      r = current_record(stim_magic, stim_version, REC_SIZE, f, d, fs, ds);
    end else if (pick < 45) begin
      r = legacy_record(stim_magic);
    end else if (pick < 52) begin
      r = $urandom_range(0, 1) ? legacy_record(wrong_magic)
                               : current_record(wrong_magic, stim_version, REC_SIZE,
                                                f, d, fs, ds);
    end else if (pick < 60) begin
      r = current_record(stim_magic, stim_version ^ (16'd1 << $urandom_range(0, 15)),
                         REC_SIZE, f, d, fs, ds);
    end else if (pick < 67) begin
      r = current_record(stim_magic, stim_version,
                         REC_SIZE ^ (16'd1 << $urandom_range(0, 15)), f, d, fs, ds);
    end else if (pick < 76) begin
      r = current_record(stim_magic, stim_version, REC_SIZE, f, d, fs, ds);
      r[20 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
    end else if (pick < 87) begin
      case ($urandom_range(0, 3))
        0: f  = pick_out(FREQ_MAX, 32'hFFFF_FFFF);
        1: d  = 16'(pick_out(32'(DUTY_MAX), 32'hFFFF));
        2: fs = 16'(pick_out(32'(FSTEP_MAX), 32'hFFFF));
        default: ds = 8'(pick_out(32'(DSTEP_MAX), 32'hFF));
      endcase
      r = current_record(stim_magic, stim_version, REC_SIZE, f, d, fs, ds);
    end else begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      // cut short: shift later records out of step
      if (pick >= 95) len = $urandom_range(1, REC_LEN - 1);
    end
    queue_record(r, len);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    int unsigned seen;
    @(negedge clk);
    seen = cfg_writes;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_MAGIC) model_magic = cfg_ch.data;
        else if (cfg_ch.index == REG_VERSION) model_version = cfg_ch.data[15:0];
        cfg_writes <= cfg_writes + 1;
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(in_ch.data_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (out_ch.valid && out_ch.ready) check_settings();
    end
  end

  always @(negedge clk) begin : byte_driver
    bit         took, nv;
    logic [7:0] nd;
    took = (bytes_taken != drv_seen);
    drv_seen = bytes_taken;
    nv = in_ch.valid;
    nd = in_ch.data_byte;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!(in_ch.valid && !took)) begin
      if (gap_left != 0) begin
        nv = 1'b0;
        gap_left--;
      end else if (bytes_pending.size() != 0) begin
        nv = 1'b1;
        nd = bytes_pending.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        nv = 1'b0;
      end
    end
    in_ch.valid     <= nv;
    in_ch.data_byte <= nd;
  end

  always @(posedge clk) begin : long_hold
    if (!long_hold_done && bytes_taken >= HOLD_AT) begin
      hold_left      <= HOLD_LEN;
      long_hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin : result_sink
    if (stall_age == 0)
      stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    stall_age = (stall_age + 1) % 64;
    out_ch.ready <= rst_n && hold_left == 0 && stall_pat[stall_age % 16];
  end

  initial begin : stimulus
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          stim_magic   = 32'h0;
          stim_version = 16'h0;
        end
        1: begin
          stim_magic   = 32'hFFFF_FFFF;
          stim_version = 16'hFFFF;
        end
        2: begin
          stim_magic   = $urandom;
          stim_version = 16'($urandom);
        end
        default: begin
          stim_magic   = $urandom;
          stim_version = 16'h0;
        end
      endcase
      write_reg(REG_MAGIC, stim_magic);
      write_reg(REG_VERSION, {16'($urandom), stim_version});
      if (p == 1) write_reg(REG_SPARE, $urandom);
      if (p == 0)
        queue_record(current_record(stim_magic, stim_version, REC_SIZE, FREQ_MAX,
                                    DUTY_MAX, FSTEP_MAX, DSTEP_MAX), REC_LEN);
      for (int k = 0; k < RECS_PER_PHASE; k++) queue_random_record();
      while (bytes_queued % REC_LEN != 0) push_byte(8'($urandom));
      do @(negedge clk); while (bytes_taken != bytes_queued || settings_due.size() != 0);
      repeat (4) @(negedge clk);
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
